### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the compensation pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define STHP_ASSERT_IMP(label, clk_i, rst_ni, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define STHP_ASSERT_NXT(label, clk_i, rst_ni, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/sthpc_pkg.sv
// ----------------------------------------------------------------------------
// sthpc_pkg
// Types and constants of the temperature / pressure / humidity compensation.
// ----------------------------------------------------------------------------
package sthpc_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_CAL_TEMP       = 3'd0,
		CFG_CAL_PRESS_A    = 3'd1,
		CFG_CAL_PRESS_B    = 3'd2,
		CFG_CAL_PRESS_NINE = 3'd3,
		CFG_CAL_HUM        = 3'd4
	} cfg_reg_e;

	typedef struct packed {
		logic [19:0] adc_temperature;
		logic [19:0] adc_pressure;
		logic [15:0] adc_humidity;
	} sample_t;

	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic [24:0]        pressure_q8;
		logic [16:0]        humidity_q10;
		logic               pressure_div_zero;
	} result_t;

	// Pipeline layout: 13 front stages, one quotient bit per divider stage, 4 back stages
	localparam int QW        = 37;
	localparam int DEN_W     = 48;
	localparam int NUM_W     = 76;
	localparam int DIV_FIRST = 14;
	localparam int DIV_LAST  = DIV_FIRST + QW - 1;
	localparam int NSTG      = DIV_LAST + 4;

	localparam logic signed [14:0] TEMP_MIN    = -15'sd4000;
	localparam logic signed [14:0] TEMP_MAX    = 15'sd8500;
	localparam logic [24:0]        PRES_MAX    = 25'h1FF_FFFF;
	localparam logic [16:0]        HUM_MAX     = 17'd102400;
	localparam logic signed [63:0] HUM_RAW_MAX = 64'sd419430400;
	localparam logic [QW-1:0]      PSAT        = QW'(64'h10_0000_0000);

	// Dividend and divisor path into the divider
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             neg;
		logic             zero;
	} pdiv_t;

	// One divider stage
	typedef struct packed {
		logic [DEN_W-1:0]   rem;
		logic [DEN_W-1:0]   den;
		logic [QW-1:0]      qn;
		logic               neg;
		logic               zero;
		logic               ovf;
		logic signed [14:0] temp;
		logic [16:0]        hum;
	} dstep_t;

	// Results that ride beside the pressure back end
	typedef struct packed {
		logic signed [14:0] temp;
		logic [16:0]        hum;
		logic               zero;
	} side_t;

endpackage

### design/sensor_thp_compensation_top.sv
// ----------------------------------------------------------------------------
// sensor_thp_compensation_top
// Fixed-point temperature, pressure and humidity compensation pipeline.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction
//  --------  ----------------------------------------  ---------
//  sample    sample_valid, sample_stall, sample        in
//  result    result_valid, result_stall, result        out
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in
//
//  One item per cycle sustained while result_stall is low; NSTG stages: 13 front stages,
//  one restoring-divider stage per quotient bit (37), 4 back stages.
//  arst_n clears every stage valid bit; calibration registers reset to zero.
//  Each stage holds only while the stage after it is full and holding, so
//  bubbles squeeze out under a result stall and new samples keep entering.
//  cfg_ready is always high; writes go straight into the calibration registers.
//
`include "assert_macros.svh"

module sensor_thp_compensation_top
	import sthpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  sample_t     sample,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	// ------------------------------------------------------------------
	// Calibration registers
	// ------------------------------------------------------------------
	logic [47:0] cal_temp_q;
	logic [63:0] cal_press_a_q;
	logic [63:0] cal_press_b_q;
	logic [15:0] cal_press_nine_q;
	logic [63:0] cal_hum_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q       <= '0;
			cal_press_a_q    <= '0;
			cal_press_b_q    <= '0;
			cal_press_nine_q <= '0;
			cal_hum_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				CFG_CAL_TEMP:       cal_temp_q       <= cfg_data[47:0];
				CFG_CAL_PRESS_A:    cal_press_a_q    <= cfg_data;
				CFG_CAL_PRESS_B:    cal_press_b_q    <= cfg_data;
				CFG_CAL_PRESS_NINE: cal_press_nine_q <= cfg_data[15:0];
				CFG_CAL_HUM:        cal_hum_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Coefficient fields; the user must write them only while idle (not enforced here), so every stage reads them live
	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic [7:0]         h1, h3;
	logic signed [11:0] h4, h5;
	logic signed [7:0]  h6;

	assign t1 = cal_temp_q[15:0];
	assign t2 = $signed(cal_temp_q[31:16]);
	assign t3 = $signed(cal_temp_q[47:32]);
	assign p1 = cal_press_a_q[15:0];
	assign p2 = $signed(cal_press_a_q[31:16]);
	assign p3 = $signed(cal_press_a_q[47:32]);
	assign p4 = $signed(cal_press_a_q[63:48]);
	assign p5 = $signed(cal_press_b_q[15:0]);
	assign p6 = $signed(cal_press_b_q[31:16]);
	assign p7 = $signed(cal_press_b_q[47:32]);
	assign p8 = $signed(cal_press_b_q[63:48]);
	assign p9 = $signed(cal_press_nine_q);
	assign h1 = cal_hum_q[7:0];
	assign h2 = $signed(cal_hum_q[23:8]);
	assign h3 = cal_hum_q[31:24];
	assign h4 = $signed(cal_hum_q[43:32]);
	assign h5 = $signed(cal_hum_q[55:44]);
	assign h6 = $signed(cal_hum_q[63:56]);

	// ------------------------------------------------------------------
	// Stage flow control: a stage loads when empty or when its content
	// moves on; the last stage is the output register.
	// ------------------------------------------------------------------
	logic [NSTG:1] vld;
	logic [NSTG:1] ld;

	assign ld[NSTG] = !vld[NSTG] || !result_stall;
	for (genvar k = 1; k < NSTG; k++) begin : g_ld
		assign ld[k] = !vld[k] || ld[k+1];
	end

	assign sample_stall = !ld[1];
	assign result_valid = vld[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (ld[1]) vld[1] <= sample_valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (ld[k]) vld[k] <= vld[k-1];
			end
		end
	end

	// Raw readings that ride along until needed
	logic [19:0] ap_s [1:6];
	logic [15:0] ah_s [1:4];

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			ap_s[1] <= sample.adc_pressure;
			ah_s[1] <= sample.adc_humidity;
		end
		for (int k = 2; k <= 6; k++) begin
			if (ld[k]) ap_s[k] <= ap_s[k-1];
		end
		for (int k = 2; k <= 4; k++) begin
			if (ld[k]) ah_s[k] <= ah_s[k-1];
		end
	end

	// ------------------------------------------------------------------
	// S1..S3: temperature and fine temperature
	// ------------------------------------------------------------------
	logic signed [17:0] td;
	logic signed [16:0] tdd;
	logic signed [33:0] v1m_s1, sq_s1;
	logic signed [22:0] v1_s2;
	logic signed [37:0] v2m_s2;
	logic signed [25:0] tf;
	logic signed [25:0] tf_s3, xp_s3, xh_s3;

	assign td  = $signed({1'b0, sample.adc_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign tdd = $signed({1'b0, sample.adc_temperature[19:4]}) - $signed({1'b0, t1});
	assign tf  = 26'(v1_s2) + 26'($signed(v2m_s2[37:14]));

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			v1m_s1 <= td * t2;
			sq_s1  <= tdd * tdd;
		end
		if (ld[2]) begin
			v1_s2  <= $signed(v1m_s1[33:11]);
			v2m_s2 <= $signed(sq_s1[33:12]) * t3;
		end
		if (ld[3]) begin
			tf_s3 <= tf;
			xp_s3 <= tf - 26'sd128000;
			xh_s3 <= tf - 26'sd76800;
		end
	end

	// ------------------------------------------------------------------
	// S4..S8: pressure polynomial and divisor, humidity terms
	// ------------------------------------------------------------------
	logic signed [29:0] t5;
	logic signed [21:0] tsh;
	logic signed [14:0] temp_d;
	logic signed [14:0] temp_s [4:12];

	assign t5  = 30'(tf_s3) * 30'sd5 + 30'sd128;
	assign tsh = t5[29:8];

	always_comb begin
		if (tsh < 22'(TEMP_MIN)) begin
			temp_d = TEMP_MIN;
		end else if (tsh > 22'(TEMP_MAX)) begin
			temp_d = TEMP_MAX;
		end else begin
			temp_d = tsh[14:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[4]) temp_s[4] <= temp_d;
		for (int k = 5; k <= 12; k++) begin
			if (ld[k]) temp_s[k] <= temp_s[k-1];
		end
	end

	logic signed [51:0] xx_s4;
	logic signed [41:0] xp5_s4, xp2_s4, xp5_s5, xp2_s5;
	logic signed [37:0] h5x_s4;
	logic signed [33:0] xh6_s4;
	logic signed [34:0] xh3_s4;
	logic signed [67:0] xxp6_s5, xxp3_s5;
	logic signed [39:0] hsum;
	logic signed [24:0] ha_s [5:9];
	logic signed [23:0] t6_s5;
	logic signed [24:0] t3h_s5;
	logic signed [63:0] v2p_s6, a_s6;
	logic signed [48:0] m_s6;
	logic signed [63:0] n_s7, hp_s7;
	logic [32:0]        lp_s7;
	logic signed [39:0] v1h_s7;
	logic signed [63:0] dsum;
	logic signed [DEN_W-1:0] den_s8;
	logic signed [76:0] n3_s8;
	logic signed [55:0] hm_s8;

	assign hsum = 40'($signed({1'b0, ah_s[4], 14'd0})) - (40'(h4) <<< 20) - 40'(h5x_s4)
		+ 40'sd16384;
	assign dsum = hp_s7 + $signed({48'd0, lp_s7[32:17]});

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			xx_s4  <= xp_s3 * xp_s3;
			xp5_s4 <= xp_s3 * p5;
			xp2_s4 <= xp_s3 * p2;
			h5x_s4 <= xh_s3 * h5;
			xh6_s4 <= xh_s3 * h6;
			xh3_s4 <= xh_s3 * $signed({1'b0, h3});
		end
		if (ld[5]) begin
			xxp6_s5 <= xx_s4 * p6;
			xxp3_s5 <= xx_s4 * p3;
			xp5_s5  <= xp5_s4;
			xp2_s5  <= xp2_s4;
			ha_s[5] <= hsum[39:15];
			t6_s5   <= xh6_s4[33:10];
			t3h_s5  <= 25'($signed(xh3_s4[34:11])) + 25'sd32768;
		end
		for (int k = 6; k <= 9; k++) begin
			if (ld[k]) ha_s[k] <= ha_s[k-1];
		end
		if (ld[6]) begin
			v2p_s6 <= $signed(xxp6_s5[63:0]) + (64'(xp5_s5) <<< 17) + (64'(p4) <<< 35);
			a_s6   <= 64'sd140737488355328 + 64'($signed(xxp3_s5[67:8]))
				+ (64'(xp2_s5) <<< 12);
			m_s6   <= t6_s5 * t3h_s5;
		end
		if (ld[7]) begin
			n_s7   <= ((64'sd1048576 - $signed(64'(ap_s[6]))) <<< 31) - v2p_s6;
			hp_s7  <= $signed(a_s6[63:17]) * $signed({1'b0, p1});
			lp_s7  <= a_s6[16:0] * p1;
			v1h_s7 <= 40'($signed(m_s6[48:10])) + 40'sd2097152;
		end
		if (ld[8]) begin
			den_s8 <= dsum[63:16];
			n3_s8  <= n_s7 * 13'sd3125;
			hm_s8  <= v1h_s7 * h2;
		end
	end

	// ------------------------------------------------------------------
	// S9..S13: divider operands, humidity finish
	// ------------------------------------------------------------------
	pdiv_t              pd_s [9:12];
	pdiv_t              pd_d;
	logic signed [55:0] hmr;
	logic signed [41:0] v1h2_s9;
	logic signed [63:0] hum_s10, hum_s11, hum_s12;
	logic [47:0]        hs;
	logic               hneg_s11, big_s11, hneg_s12, big_s12;
	logic [61:0]        ss_s11;
	logic [62:0]        corr_s12;
	logic signed [63:0] hd;
	logic [16:0]        hum_d;
	dstep_t             dv_s [DIV_FIRST-1:DIV_LAST];
	dstep_t             dv0;

	always_comb begin
		pd_d.neg  = n3_s8[76] ^ den_s8[DEN_W-1];
		pd_d.zero = (den_s8 == '0);
		pd_d.num  = n3_s8[76] ? NUM_W'(-n3_s8) : n3_s8[NUM_W-1:0];
		pd_d.den  = den_s8[DEN_W-1] ? DEN_W'(-den_s8) : den_s8;
	end

	assign hmr = hm_s8 + 56'sd8192;
	assign hs  = hum_s10[62:15];

	// Quadratic H1 correction; a negative value, or a huge one when H1 is nonzero, drops to zero
	always_comb begin
		if (hneg_s12 || (h1 != '0 && big_s12)) begin
			hd = '0;
		end else begin
			hd = hum_s12 - $signed({5'd0, corr_s12[62:4]});
		end
		if (hd < 0) begin
			hum_d = '0;
		end else if (hd > HUM_RAW_MAX) begin
			hum_d = HUM_MAX;
		end else begin
			hum_d = hd[28:12];
		end
	end

	always_comb begin
		dv0.rem  = DEN_W'(pd_s[12].num[NUM_W-1:QW]);
		dv0.den  = pd_s[12].den;
		dv0.qn   = pd_s[12].num[QW-1:0];
		dv0.neg  = pd_s[12].neg;
		dv0.zero = pd_s[12].zero;
		dv0.ovf  = (DEN_W'(pd_s[12].num[NUM_W-1:QW]) >= pd_s[12].den);
		dv0.temp = temp_s[12];
		dv0.hum  = hum_d;
	end

	always_ff @(posedge clk) begin
		if (ld[9]) begin
			pd_s[9] <= pd_d;
			v1h2_s9 <= hmr[55:14];
		end
		for (int k = 10; k <= 12; k++) begin
			if (ld[k]) pd_s[k] <= pd_s[k-1];
		end
		if (ld[10]) hum_s10 <= ha_s[9] * v1h2_s9;
		if (ld[11]) begin
			hum_s11  <= hum_s10;
			hneg_s11 <= hum_s10[63];
			big_s11  <= |hs[47:31];
			ss_s11   <= hs[30:0] * hs[30:0];
		end
		if (ld[12]) begin
			hum_s12  <= hum_s11;
			hneg_s12 <= hneg_s11;
			big_s12  <= big_s11;
			corr_s12 <= ss_s11[61:7] * h1;
		end
		if (ld[DIV_FIRST-1]) dv_s[DIV_FIRST-1] <= dv0;
	end

	// ------------------------------------------------------------------
	// S14..S50: restoring divider, one quotient bit per stage
	// ------------------------------------------------------------------
	function automatic dstep_t div_step(input dstep_t d);
		logic [DEN_W:0] t;
		logic           ge;
		dstep_t         r;
		r     = d;
		t     = {d.rem, d.qn[QW-1]};
		ge    = (t >= {1'b0, d.den});
		r.rem = ge ? (t[DEN_W-1:0] - d.den) : t[DEN_W-1:0];
		r.qn  = {d.qn[QW-2:0], ge};
		return r;
	endfunction

	for (genvar k = DIV_FIRST; k <= DIV_LAST; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (ld[k]) dv_s[k] <= div_step(dv_s[k-1]);
		end
	end

	// ------------------------------------------------------------------
	// S51..S54: saturate quotient, P7..P9 correction, output register
	// ------------------------------------------------------------------
	logic [QW-1:0]      mag;
	logic signed [37:0] p_s51, p_s52, p_s53;
	side_t              side_s [51:53];
	logic signed [49:0] pp_s52;
	logic signed [53:0] p8p_s52;
	logic signed [65:0] v1t_s53;
	logic signed [34:0] v2_s53;
	logic signed [41:0] psum;
	logic signed [33:0] pres;
	result_t            result_d;
	result_t            result_q;

	assign mag = (dv_s[DIV_LAST].ovf || dv_s[DIV_LAST].qn > PSAT) ? PSAT : dv_s[DIV_LAST].qn;

	assign psum = 42'(p_s53) + 42'($signed(v1t_s53[65:25])) + 42'(v2_s53);
	assign pres = 34'($signed(psum[41:8])) + (34'(p7) <<< 4);

	always_comb begin
		result_d.temperature_centi = side_s[53].temp;
		result_d.humidity_q10      = side_s[53].hum;
		result_d.pressure_div_zero = side_s[53].zero;
		if (side_s[53].zero || pres < 0) begin
			result_d.pressure_q8 = '0;
		end else if (pres > 34'(PRES_MAX)) begin
			result_d.pressure_q8 = PRES_MAX;
		end else begin
			result_d.pressure_q8 = pres[24:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[51]) begin
			p_s51          <= dv_s[DIV_LAST].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			side_s[51].temp <= dv_s[DIV_LAST].temp;
			side_s[51].hum  <= dv_s[DIV_LAST].hum;
			side_s[51].zero <= dv_s[DIV_LAST].zero;
		end
		if (ld[52]) begin
			p_s52      <= p_s51;
			pp_s52     <= $signed(p_s51[37:13]) * $signed(p_s51[37:13]);
			p8p_s52    <= p_s51 * p8;
			side_s[52] <= side_s[51];
		end
		if (ld[53]) begin
			p_s53      <= p_s52;
			v1t_s53    <= pp_s52 * p9;
			v2_s53     <= p8p_s52[53:19];
			side_s[53] <= side_s[52];
		end
		if (ld[NSTG]) result_q <= result_d;
	end

	assign result = result_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`STHP_ASSERT_IMP(a_div_zero_pres, clk, arst_n, result_valid && result.pressure_div_zero,
		result.pressure_q8 == '0, "pressure not zero on zero divisor")
	`STHP_ASSERT_IMP(a_hum_range, clk, arst_n, result_valid,
		result.humidity_q10 <= HUM_MAX, "humidity above full scale")
	`STHP_ASSERT_IMP(a_temp_range, clk, arst_n, result_valid,
		result.temperature_centi >= TEMP_MIN && result.temperature_centi <= TEMP_MAX,
		"temperature outside saturation range")
	`STHP_ASSERT_IMP(a_stall_full, clk, arst_n, sample_stall, &vld,
		"sample stalled with an empty stage")

endmodule
